@@ hdl/cc20_pkg.sv @@
// shared types, constants and round functions of the chacha20 keystream xor block
// no dependencies; imported by every module under hdl
`timescale 1ns / 1ps

package cc20_pkg;

	localparam int WORD_W          = 32;
	localparam int KEY_REG_W       = 64;
	localparam int NUM_KEY_REGS    = 4;
	localparam int NUM_WORDS       = 16;
	localparam int POS_W           = $clog2(NUM_WORDS);
	localparam int NUM_ROUNDS      = 20;
	localparam int RND_W           = $clog2(NUM_ROUNDS);
	localparam int CNT_W           = 3;
	localparam int CFG_IDX_W       = 3;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam logic [WORD_W-1:0] INIT_CTR_RST = 32'd1;

	// "expand 32-byte k"
	localparam logic [WORD_W-1:0] SIGMA_0 = 32'h6170_7865;
	localparam logic [WORD_W-1:0] SIGMA_1 = 32'h3320_646e;
	localparam logic [WORD_W-1:0] SIGMA_2 = 32'h7962_2d32;
	localparam logic [WORD_W-1:0] SIGMA_3 = 32'h6b20_6574;

	localparam logic [CNT_W-1:0] CNT_ONE   = 3'd1;
	localparam logic [CNT_W-1:0] CNT_TWO   = 3'd2;
	localparam logic [CNT_W-1:0] CNT_THREE = 3'd3;
	localparam logic [CNT_W-1:0] CNT_FOUR  = 3'd4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY0,
		REG_KEY1,
		REG_KEY2,
		REG_KEY3,
		REG_NONCE_LO,
		REG_NONCE_HI,
		REG_INIT_CTR
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FINAL,
		ST_READY
	} back_state_t;

	typedef logic [NUM_WORDS-1:0][WORD_W-1:0] block_t;

	typedef struct packed {
		logic [WORD_W-1:0] data_in;
		logic [CNT_W-1:0]  byte_count;
		logic              last;
	} in_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] data_out;
		logic [CNT_W-1:0]  out_byte_count;
		logic              out_last;
	} out_item_t;

	typedef struct packed {
		logic [NUM_KEY_REGS-1:0][KEY_REG_W-1:0] key;
		logic [KEY_REG_W-1:0]                   nonce_low;
		logic [WORD_W-1:0]                      nonce_high;
	} key_cfg_t;

	// classified request as it sits in the queue
	typedef struct packed {
		logic [WORD_W-1:0] data;
		logic [CNT_W-1:0]  count;
		logic              last;
		logic [POS_W-1:0]  pos;
		logic              need_blk;
		logic [WORD_W-1:0] blk_ctr;
	} q_item_t;

	typedef struct packed {
		logic gen_busy;
		logic deq;
	} back_status_t;

	function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int unsigned n);
		return (v << n) | (v >> (WORD_W - n));
	endfunction

	// q[0..3] = a, b, c, d
	function automatic logic [3:0][WORD_W-1:0] quarter(input logic [3:0][WORD_W-1:0] q);
		logic [WORD_W-1:0] a, b, c, d;
		a = q[0];
		b = q[1];
		c = q[2];
		d = q[3];
		a = a + b; d = rotl(d ^ a, 16);
		c = c + d; b = rotl(b ^ c, 12);
		a = a + b; d = rotl(d ^ a, 8);
		c = c + d; b = rotl(b ^ c, 7);
		return {d, c, b, a};
	endfunction

	// one column round, or one diagonal round when diag is set
	function automatic block_t half_round(input block_t x, input logic diag);
		block_t                  y;
		logic [3:0][WORD_W-1:0]  q;
		logic [POS_W-1:0]        ia, ib, ic, id;
		y = x;
		for (int i = 0; i < 4; i++) begin
			ia = POS_W'(i);
			ib = diag ? POS_W'(4 + ((i + 1) & 3)) : POS_W'(4 + i);
			ic = diag ? POS_W'(8 + ((i + 2) & 3)) : POS_W'(8 + i);
			id = diag ? POS_W'(12 + ((i + 3) & 3)) : POS_W'(12 + i);
			q = quarter({x[id], x[ic], x[ib], x[ia]});
			y[ia] = q[0];
			y[ib] = q[1];
			y[ic] = q[2];
			y[id] = q[3];
		end
		return y;
	endfunction

	function automatic block_t init_block(input key_cfg_t c, input logic [WORD_W-1:0] ctr);
		block_t s;
		s[0] = SIGMA_0;
		s[1] = SIGMA_1;
		s[2] = SIGMA_2;
		s[3] = SIGMA_3;
		for (int i = 0; i < NUM_KEY_REGS; i++) begin
			s[4 + 2 * i]     = c.key[i][WORD_W-1:0];
			s[4 + 2 * i + 1] = c.key[i][KEY_REG_W-1:WORD_W];
		end
		s[12] = ctr;
		s[13] = c.nonce_low[WORD_W-1:0];
		s[14] = c.nonce_low[KEY_REG_W-1:WORD_W];
		s[15] = c.nonce_high;
		return s;
	endfunction

endpackage

@@ hdl/cc20_front.sv @@
// front end: configuration registers, request classification, block counter and word position
// depends on cc20_pkg
`timescale 1ns / 1ps

module cc20_front import cc20_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [KEY_REG_W-1:0] cfg_data,
	input  logic                 push,
	input  logic                 full,
	input  in_item_t             item,
	output logic                 enq,
	output q_item_t              q_wr,
	output key_cfg_t             key_cfg
);

	key_cfg_t          key_cfg_q;
	logic [WORD_W-1:0] init_ctr_q;
	logic [WORD_W-1:0] ctr_q;
	logic [POS_W-1:0]  pos_q;
	logic [CNT_W-1:0]  count;

	assign enq     = push && !full;
	assign key_cfg = key_cfg_q;

	// clamp the byte count to one..four
	always_comb begin
		case (item.byte_count) inside
			3'd0:          count = CNT_ONE;
			[3'd1 : 3'd4]: count = item.byte_count;
			default:       count = CNT_FOUR;
		endcase
	end

	always_comb begin
		q_wr.data     = item.data_in;
		q_wr.count    = count;
		q_wr.last     = item.last;
		q_wr.pos      = pos_q;
		q_wr.need_blk = (pos_q == '0);
		q_wr.blk_ctr  = ctr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_cfg_q  <= '0;
			init_ctr_q <= INIT_CTR_RST;
			ctr_q      <= INIT_CTR_RST;
			pos_q      <= '0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_KEY0:     key_cfg_q.key[0]    <= cfg_data;
				REG_KEY1:     key_cfg_q.key[1]    <= cfg_data;
				REG_KEY2:     key_cfg_q.key[2]    <= cfg_data;
				REG_KEY3:     key_cfg_q.key[3]    <= cfg_data;
				REG_NONCE_LO: key_cfg_q.nonce_low <= cfg_data;
				REG_NONCE_HI: key_cfg_q.nonce_high <= cfg_data[WORD_W-1:0];
				REG_INIT_CTR: begin
					init_ctr_q <= cfg_data[WORD_W-1:0];
					ctr_q      <= cfg_data[WORD_W-1:0];
				end
				default: ;
			endcase
		end else if (enq) begin
			if (item.last) begin
				pos_q <= '0;
				ctr_q <= init_ctr_q;
			end else begin
				pos_q <= pos_q + 1'b1;
				if (pos_q == '0) begin
					ctr_q <= ctr_q + 1'b1;
				end
			end
		end
	end

endmodule

@@ hdl/cc20_queue.sv @@
// short request queue between front and back end
// depends on cc20_pkg
`timescale 1ns / 1ps

module cc20_queue import cc20_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr_en,
	input  q_item_t wr_item,
	input  logic    rd_en,
	output q_item_t rd_item,
	output logic    not_empty,
	output logic    full
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int LVL_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(DEPTH);

	q_item_t           entries_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [LVL_W-1:0]  level_q;

	assign rd_item   = entries_q[rd_ptr_q];
	assign not_empty = (level_q != '0);
	assign full      = (level_q == LVL_FULL);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entries_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				level_q <= level_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

@@ hdl/cc20_back.sv @@
// back end: iterated chacha20 round core, keystream block cache, xor and result register
// depends on cc20_pkg
`timescale 1ns / 1ps

module cc20_back import cc20_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  key_cfg_t     key_cfg,
	input  logic         head_valid,
	input  q_item_t      head,
	input  logic         pop,
	output logic         deq,
	output logic         empty,
	output out_item_t    result,
	output back_status_t status
);

	localparam logic [RND_W-1:0] RND_LAST = RND_W'(NUM_ROUNDS - 1);

	back_state_t       state_q, state_nxt;
	logic [RND_W-1:0]  round_q;
	block_t            x_q;
	block_t            init_s;
	logic              res_valid_q;
	out_item_t         res_q;
	logic              out_free;
	logic              emit;
	logic              start;
	logic [WORD_W-1:0] mask;

	assign init_s   = init_block(key_cfg, head.blk_ctr);
	assign out_free = !res_valid_q || pop;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (head_valid && head.need_blk) state_nxt = ST_ROUND;
			end
			ST_ROUND: begin
				if (round_q == RND_LAST) state_nxt = ST_FINAL;
			end
			ST_FINAL: state_nxt = ST_READY;
			ST_READY: begin
				if (head_valid && out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		start = 1'b0;
		emit  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				start = head_valid && head.need_blk;
				emit  = head_valid && !head.need_blk && out_free;
			end
			ST_READY: emit = head_valid && out_free;
			default: ;
		endcase
	end

	always_comb begin
		case (head.count)
			CNT_ONE:   mask = 32'h0000_00ff;
			CNT_TWO:   mask = 32'h0000_ffff;
			CNT_THREE: mask = 32'h00ff_ffff;
			default:   mask = 32'hffff_ffff;
		endcase
	end

	assign deq             = emit;
	assign empty           = !res_valid_q;
	assign result          = res_q;
	assign status.gen_busy = (state_q == ST_ROUND) || (state_q == ST_FINAL);
	assign status.deq      = emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			round_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (start) begin
				round_q <= '0;
			end else if (state_q == ST_ROUND) begin
				round_q <= round_q + 1'b1;
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// working state doubles as the cached keystream block
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= init_s;
		end else if (state_q == ST_ROUND) begin
			x_q <= half_round(x_q, round_q[0]);
		end else if (state_q == ST_FINAL) begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				x_q[i] <= x_q[i] + init_s[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q.data_out       <= (head.data ^ x_q[head.pos]) & mask;
			res_q.out_byte_count <= head.count;
			res_q.out_last       <= head.last;
		end
	end

endmodule

@@ hdl/chacha20_keystream_xor.sv @@
// chacha20 keystream xor top level: front end, request queue, round core back end
// depends on cc20_pkg, cc20_front, cc20_queue, cc20_back
`timescale 1ns / 1ps

// ChaCha20 stream cipher (20 rounds, 96-bit nonce, 32-bit block counter). Message words
// enter through a queue-style port (push/full) and leave through another (empty/pop),
// each result being the input word xor the next keystream word, with bytes above the
// valid count forced to zero. Key, nonce and initial counter live in configuration
// registers written through cfg_valid/cfg_ready (always ready); write them only while
// no request is in flight. Writing the initial counter also reloads the running block
// counter; a word flagged last makes the next word restart at the initial counter.
// Timing: a request moves into the internal queue in the cycle it is pushed. Words
// that reuse the cached keystream block leave at one per cycle as long as results are
// popped. The first word of each 64-byte block waits for the round core, which does
// one column or diagonal round per cycle: it loads the state, runs all rounds, does the
// feed-forward add and then xors the word into the result register. The queue holds
// up to QUEUE_DEPTH requests while the core runs; once it is filled, full stays high
// until the block is ready and the queue starts to drain.

module chacha20_keystream_xor import cc20_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// request side
	input  logic                 push,
	output logic                 full,
	input  in_item_t             item,
	// result side
	output logic                 empty,
	input  logic                 pop,
	output out_item_t            result,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [KEY_REG_W-1:0] cfg_data
);

	// front to queue
	logic         enq;
	q_item_t      q_wr;
	key_cfg_t     key_cfg;

	// queue to back
	logic         q_valid;
	q_item_t      q_head;
	logic         q_deq;
	back_status_t back_status;

	assign cfg_ready = 1'b1;

	// classifies each request: clamps byte count, tags word position and block counter
	cc20_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.item      (item),
		.enq       (enq),
		.q_wr      (q_wr),
		.key_cfg   (key_cfg)
	);

	// decouples input acceptance from block generation
	cc20_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (enq),
		.wr_item   (q_wr),
		.rd_en     (q_deq),
		.rd_item   (q_head),
		.not_empty (q_valid),
		.full      (full)
	);

	// runs the round core when a request opens a new block, then xors and registers
	cc20_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.key_cfg    (key_cfg),
		.head_valid (q_valid),
		.head       (q_head),
		.pop        (pop),
		.deq        (q_deq),
		.empty      (empty),
		.result     (result),
		.status     (back_status)
	);

	// the round core only runs for a waiting request that opens a block
	a_gen_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		back_status.gen_busy |-> (q_valid && q_head.need_blk))
		else $error("round core busy without a block-opening request at the queue head");

	// a request leaves the queue only when the result register has room
	a_deq_room: assert property (@(posedge clk) disable iff (!arst_n)
		back_status.deq |-> (empty || pop))
		else $error("request dequeued while the result register is occupied");

	// every dequeued request shows up as a result in the next cycle
	a_deq_result: assert property (@(posedge clk) disable iff (!arst_n)
		q_deq |=> !empty)
		else $error("dequeued request did not reach the result register");

endmodule
